// ----- hw/rtl/dmf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dmf_pkg;

  // Number of recent messages kept in the ring (1 to 256).
  localparam int unsigned RING_DEPTH = 16;

  localparam int unsigned IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);

  localparam int unsigned IN_DATA_W  = 160;
  localparam int unsigned OUT_DATA_W = 8;

  // Packed so that sender_addr_high sits in the lowest bits, as on tdata.
  typedef struct packed {
    logic [15:0] msg_id;
    logic [15:0] port;
    logic [63:0] addr_low;
    logic [63:0] addr_high;
  } entry_t;

endpackage

`default_nettype wire

// ----- hw/rtl/duplicate_message_filter.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Duplicate message filter. Each input transaction carries one message header
// (sender address, port and message id); the block answers with one output
// transaction whose bit 0 is 1 when the same header is already held in its
// ring of dmf_pkg::RING_DEPTH recent messages, and 0 when the header was new
// and has been recorded, overwriting the oldest entry once the ring is full.
// The ring is a single-port memory scanned one entry per cycle through one
// shared comparator. For a new header the whole ring is scanned before the
// result is raised; a header that matches entry k ends the scan early at
// that entry. The next message can be accepted once the result has been
// loaded into the output register. A result that is not taken at once waits
// in the output register while the next message is scanned; the input is
// held off only when a second result is ready before the first has been
// taken. Entries become valid only when written; no clearing pass is needed
// after reset.
module duplicate_message_filter (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // Fields from bit 0: sender_addr_high[63:0], sender_addr_low[63:0],
  // sender_port[15:0], msg_id[15:0].
  input  wire logic [dmf_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // Fields from bit 0: is_duplicate, then seven zero bits.
  output logic [dmf_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_HOLD
  } state_e;

  state_e                      state_q;
  dmf_pkg::entry_t             key_q;
  dmf_pkg::entry_t             rd_q;
  dmf_pkg::entry_t             mem_q [dmf_pkg::RING_DEPTH];
  logic [dmf_pkg::RING_DEPTH-1:0] valid_q;
  logic                        vrd_q;
  logic [dmf_pkg::CNT_W-1:0]   idx_q;
  logic                        cmp_vld_q;
  logic [dmf_pkg::IDX_W-1:0]   slot_q;
  logic                        out_valid_q;
  logic                        out_dup_q;
  logic                        res_q;

  logic                        rd_en;
  logic [dmf_pkg::IDX_W-1:0]   rd_idx;
  logic                        hit;
  logic                        last;
  logic                        done;
  logic                        wr_en;
  logic                        out_free;
  logic                        out_load;
  logic                        in_acc;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(dmf_pkg::OUT_DATA_W-1){1'b0}}, out_dup_q};

  assign rd_en    = (state_q == S_SCAN) && (idx_q < dmf_pkg::CNT_W'(dmf_pkg::RING_DEPTH));
  assign rd_idx   = idx_q[dmf_pkg::IDX_W-1:0];
  // The comparator looks at the entry read in the previous cycle.
  assign hit      = cmp_vld_q && vrd_q && (rd_q == key_q);
  assign last     = cmp_vld_q && (idx_q == dmf_pkg::CNT_W'(dmf_pkg::RING_DEPTH));
  assign done     = (state_q == S_SCAN) && (hit || last);
  assign wr_en    = done && !hit;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign out_load = out_free && (done || (state_q == S_HOLD));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[slot_q] <= key_q;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      key_q       <= '0;
      valid_q     <= '0;
      vrd_q       <= 1'b0;
      idx_q       <= '0;
      cmp_vld_q   <= 1'b0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
      out_dup_q   <= 1'b0;
      res_q       <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_dup_q   <= (state_q == S_HOLD) ? res_q : hit;
      end else if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (rd_en) begin
        vrd_q <= valid_q[rd_idx];
      end
      if (wr_en) begin
        valid_q[slot_q] <= 1'b1;
        if (slot_q == dmf_pkg::IDX_W'(dmf_pkg::RING_DEPTH - 1)) begin
          slot_q <= '0;
        end else begin
          slot_q <= slot_q + 1'b1;
        end
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            key_q     <= dmf_pkg::entry_t'(s_axis_tdata_i);
            idx_q     <= '0;
            cmp_vld_q <= 1'b0;
            state_q   <= S_SCAN;
          end
        end
        S_SCAN: begin
          cmp_vld_q <= rd_en && !done;
          if (rd_en) begin
            idx_q <= idx_q + 1'b1;
          end
          if (done) begin
            if (out_free) begin
              state_q <= S_IDLE;
            end else begin
              res_q   <= hit;
              state_q <= S_HOLD;
            end
          end
        end
        S_HOLD: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
